@@ src/bmft_pkg.sv @@
// shared constants, types and helpers for the block-mapped flash translation controller
// no dependencies; imported by every module of the block
`default_nettype none

package bmft_pkg;

    localparam int PAGES_PER_BLK = 8;
    localparam int BLOCK_COUNT   = 16;
    localparam int DATA_BLKS     = BLOCK_COUNT - 1;
    localparam int PAGE_W        = $clog2(PAGES_PER_BLK);
    localparam int BLK_W         = $clog2(BLOCK_COUNT);
    localparam int PPN_W         = 7;
    localparam int LSN_W         = 7;

    // flash command codes
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_PROG  = 3'd1;
    localparam logic [2:0] OP_COPY  = 3'd2;
    localparam logic [2:0] OP_MARK  = 3'd3;
    localparam logic [2:0] OP_ERASE = 3'd4;
    localparam logic [2:0] OP_NONE  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;
    localparam logic [1:0] ST_NOFREE   = 2'd3;

    // datapath actions issued by the controller
    typedef logic [3:0] act_t;
    localparam act_t ACT_NOP       = 4'd0;
    localparam act_t ACT_CAPTURE   = 4'd1;
    localparam act_t ACT_LOOKUP    = 4'd2;
    localparam act_t ACT_STATUS    = 4'd3;
    localparam act_t ACT_READ      = 4'd4;
    localparam act_t ACT_PROG_OLD  = 4'd5;
    localparam act_t ACT_SCAN_STEP = 4'd6;
    localparam act_t ACT_ALLOC     = 4'd7;
    localparam act_t ACT_MARK      = 4'd8;
    localparam act_t ACT_COPY      = 4'd9;
    localparam act_t ACT_COPY_STEP = 4'd10;
    localparam act_t ACT_MPROG     = 4'd11;
    localparam act_t ACT_ERASE     = 4'd12;

    typedef struct packed {
        logic             req_type;
        logic [LSN_W-1:0] lsn;
    } req_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [PPN_W-1:0] dst_ppn;
        logic [PPN_W-1:0] src_ppn;
        logic [BLK_W-1:0] spare_lbn;
        logic             has_lbn;
        logic [LSN_W-1:0] spare_lsn;
        logic             has_lsn;
        logic [1:0]       status;
        logic             last;
    } res_t;

    typedef struct packed {
        act_t       act;
        logic [1:0] st;
        logic       last;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_range;
        logic is_write;
        logic mapped;
        logic page_set;
        logic off_zero;
        logic free_hit;
        logic scan_last;
        logic copy_skip;
        logic copy_last;
    } ctl_stat_t;

    function automatic logic [PPN_W-1:0] ppn_of(input logic [BLK_W-1:0] blk,
                                                 input logic [PAGE_W-1:0] pg);
        return PPN_W'(int'(blk) * PAGES_PER_BLK + int'(pg));
    endfunction

endpackage

`default_nettype wire

@@ src/block_mapped_flash_translation.sv @@
// top level of the block-mapped flash translation controller
// depends on bmft_pkg, bmft_ctrl and bmft_dp
`default_nettype none

// A request (read or write of one logical sector) is taken when start is high and
// busy is low. The block answers with one or more flash commands, each shown on
// result for exactly one cycle with strobe high; the last command of a request has
// result.last set. The receiver cannot stall: every strobe cycle is a transfer and
// must be captured. Commands come one per cycle at most, from a registered output,
// so each is on the port in the cycle after the sequencer issues it. A read, an
// error or an in-place program passes through capture, lookup and decide; a first
// write adds the allocation scan, one step per physical block looked at (up to 16),
// plus the lbn marker when needed; a merge adds the page-by-page copy loop over the
// pages of a block (8), the spare program and the erase. A new request can be taken
// in the cycle that its predecessor's last command is on the port.
module block_mapped_flash_translation
    import bmft_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      strobe,
    output res_t      result
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // sequencer: lookup, allocation scan, merge steps
    bmft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // map, spare, taken and written-page state plus the command register
    bmft_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .stat   (stat),
        .strobe (strobe),
        .result (result)
    );

endmodule

`default_nettype wire

@@ src/bmft_ctrl.sv @@
// request sequencer: walks each request through lookup, allocation scan or merge
// depends on bmft_pkg; drives bmft_dp through ctl_cmd_t
`default_nettype none

module bmft_ctrl
    import bmft_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire ctl_stat_t stat,
    output ctl_cmd_t       cmd,
    output logic           busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_MARK   = 3'd4;
    localparam logic [2:0] S_COPY   = 3'd5;
    localparam logic [2:0] S_MPROG  = 3'd6;
    localparam logic [2:0] S_ERASE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.act    = ACT_NOP;
        cmd.st     = ST_OK;
        cmd.last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.act    = ACT_CAPTURE;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.act    = ACT_LOOKUP;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (stat.out_range)
                begin
                    cmd.act    = ACT_STATUS;
                    cmd.st     = ST_RANGE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!stat.is_write)
                begin
                    cmd.act    = stat.mapped ? ACT_READ : ACT_STATUS;
                    cmd.st     = stat.mapped ? ST_OK : ST_UNMAPPED;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!stat.mapped)
                begin
                    state_next = S_SCAN;
                end
                else if (!stat.page_set)
                begin
                    cmd.act    = ACT_PROG_OLD;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_COPY;
                end
            end
            S_SCAN:
            begin
                priority if (stat.free_hit)
                begin
                    cmd.act    = ACT_ALLOC;
                    cmd.last   = stat.off_zero;
                    state_next = stat.off_zero ? S_IDLE : S_MARK;
                end
                else if (stat.scan_last)
                begin
                    cmd.act    = ACT_STATUS;
                    cmd.st     = ST_NOFREE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.act = ACT_SCAN_STEP;
                end
            end
            S_MARK:
            begin
                cmd.act    = ACT_MARK;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                cmd.act = stat.copy_skip ? ACT_COPY_STEP : ACT_COPY;
                if (stat.copy_last)
                begin
                    state_next = S_MPROG;
                end
            end
            S_MPROG:
            begin
                cmd.act    = ACT_MPROG;
                state_next = S_ERASE;
            end
            S_ERASE:
            begin
                cmd.act    = ACT_ERASE;
                cmd.last   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/bmft_dp.sv @@
// translation datapath: block map, spare and taken tracking, page written rows,
// scan and copy counters, result register; depends on bmft_pkg
`default_nettype none

module bmft_dp
    import bmft_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire ctl_cmd_t cmd,
    output ctl_stat_t     stat,
    output logic          strobe,
    output res_t          result
);

    req_t                     req_reg;
    logic [BLK_W-1:0]         pbn_reg;
    logic                     mapped_reg;
    logic [BLK_W-1:0]         map_pbn_reg [DATA_BLKS];
    logic [DATA_BLKS-1:0]     map_valid_reg;
    logic [BLK_W-1:0]         spare_reg;
    logic [BLOCK_COUNT-1:0]   taken_reg;
    logic [PAGES_PER_BLK-1:0] pw_reg [BLOCK_COUNT];
    logic [BLK_W-1:0]         scan_reg;
    logic [PAGE_W-1:0]        copy_reg;
    res_t                     res_reg;
    res_t                     res_next;
    logic                     strobe_reg;
    logic                     strobe_next;

    logic [BLK_W-1:0]         lbn;
    logic [BLK_W-1:0]         lbn_idx;
    logic [PAGE_W-1:0]        off;
    logic                     off_zero;
    logic                     out_range;
    logic [PAGES_PER_BLK-1:0] row;
    logic [PAGES_PER_BLK-1:0] pg_mask;
    res_t                     prog_tpl;

    assign lbn       = BLK_W'(req_reg.lsn / PAGES_PER_BLK);
    assign off       = PAGE_W'(req_reg.lsn % PAGES_PER_BLK);
    assign off_zero  = (off == '0);
    assign out_range = (lbn >= BLK_W'(DATA_BLKS));
    assign lbn_idx   = out_range ? '0 : lbn;
    assign row       = pw_reg[pbn_reg];

    always_comb
    begin
        pg_mask      = '0;
        pg_mask[off] = 1'b1;
    end

    assign stat.out_range = out_range;
    assign stat.is_write  = req_reg.req_type;
    assign stat.mapped    = mapped_reg;
    assign stat.page_set  = row[off];
    assign stat.off_zero  = off_zero;
    assign stat.free_hit  = (scan_reg != spare_reg) && !taken_reg[scan_reg];
    assign stat.scan_last = (scan_reg == BLK_W'(BLOCK_COUNT - 1));
    assign stat.copy_skip = (copy_reg == off);
    assign stat.copy_last = (copy_reg == PAGE_W'(PAGES_PER_BLK - 1));

    // host page program fields, destination filled per case
    always_comb
    begin
        prog_tpl           = '0;
        prog_tpl.op        = OP_PROG;
        prog_tpl.spare_lbn = off_zero ? lbn : '0;
        prog_tpl.has_lbn   = off_zero;
        prog_tpl.spare_lsn = req_reg.lsn;
        prog_tpl.has_lsn   = 1'b1;
        prog_tpl.status    = ST_OK;
    end

    always_comb
    begin
        res_next    = '0;
        strobe_next = 1'b0;
        unique case (cmd.act)
            ACT_STATUS:
            begin
                res_next.op     = OP_NONE;
                res_next.status = cmd.st;
                strobe_next     = 1'b1;
            end
            ACT_READ:
            begin
                res_next.op      = OP_READ;
                res_next.dst_ppn = ppn_of(pbn_reg, off);
                strobe_next      = 1'b1;
            end
            ACT_PROG_OLD:
            begin
                res_next         = prog_tpl;
                res_next.dst_ppn = ppn_of(pbn_reg, off);
                strobe_next      = 1'b1;
            end
            ACT_ALLOC:
            begin
                res_next         = prog_tpl;
                res_next.dst_ppn = ppn_of(scan_reg, off);
                strobe_next      = 1'b1;
            end
            ACT_MARK:
            begin
                res_next.op        = OP_MARK;
                res_next.dst_ppn   = ppn_of(pbn_reg, '0);
                res_next.spare_lbn = lbn;
                res_next.has_lbn   = 1'b1;
                strobe_next        = 1'b1;
            end
            ACT_COPY:
            begin
                res_next.op      = OP_COPY;
                res_next.dst_ppn = ppn_of(spare_reg, copy_reg);
                res_next.src_ppn = ppn_of(pbn_reg, copy_reg);
                strobe_next      = 1'b1;
            end
            ACT_MPROG:
            begin
                res_next         = prog_tpl;
                res_next.dst_ppn = ppn_of(spare_reg, off);
                strobe_next      = 1'b1;
            end
            ACT_ERASE:
            begin
                res_next.op      = OP_ERASE;
                res_next.dst_ppn = ppn_of(pbn_reg, '0);
                strobe_next      = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
        res_next.last = cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg    <= 1'b0;
            map_valid_reg <= '0;
            spare_reg     <= BLK_W'(BLOCK_COUNT - 1);
            taken_reg     <= '0;
            for (int b = 0; b < BLOCK_COUNT; b++)
            begin
                pw_reg[b] <= '0;
            end
        end
        else
        begin
            strobe_reg <= strobe_next;
            unique case (cmd.act)
                ACT_PROG_OLD:
                begin
                    pw_reg[pbn_reg] <= row | pg_mask;
                end
                ACT_ALLOC:
                begin
                    map_valid_reg[lbn_idx] <= 1'b1;
                    taken_reg[scan_reg]    <= 1'b1;
                    pw_reg[scan_reg]       <= pw_reg[scan_reg] | pg_mask;
                end
                ACT_MPROG:
                begin
                    // spare takes the old row, copies keep their written bits
                    pw_reg[spare_reg] <= row | pg_mask;
                end
                ACT_ERASE:
                begin
                    taken_reg[spare_reg] <= 1'b1;
                    taken_reg[pbn_reg]   <= 1'b0;
                    pw_reg[pbn_reg]      <= '0;
                    spare_reg            <= pbn_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and map contents, guarded by the valid bits above
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        unique case (cmd.act)
            ACT_CAPTURE:
            begin
                req_reg <= req;
            end
            ACT_LOOKUP:
            begin
                pbn_reg    <= map_pbn_reg[lbn_idx];
                mapped_reg <= map_valid_reg[lbn_idx];
                scan_reg   <= '0;
                copy_reg   <= '0;
            end
            ACT_SCAN_STEP:
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            ACT_ALLOC:
            begin
                map_pbn_reg[lbn_idx] <= scan_reg;
                pbn_reg              <= scan_reg;
            end
            ACT_COPY, ACT_COPY_STEP:
            begin
                copy_reg <= copy_reg + 1'b1;
            end
            ACT_ERASE:
            begin
                map_pbn_reg[lbn_idx] <= spare_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ tb/tb_block_mapped_flash_translation.sv @@
// self-checking testbench for the block-mapped flash translation controller
// depends on bmft_pkg and block_mapped_flash_translation; checks every flash command
// against a behavioral translation map kept alongside the block
`default_nettype none

module tb_block_mapped_flash_translation;
    import bmft_pkg::*;

    // cycles with no transfer on either side before the run is declared hung;
    // the limit lies far above the slowest request plus the largest sender gap
    localparam int HANG_LIMIT = 2000;
    // quiet cycles after the last command, longer than a full merge
    localparam int DRAIN_CYCLES = 40;

    // one queued host request with its pre-issue gap and an optional
    // wait-for-empty hold-off
    typedef struct {
        req_t        r;
        int unsigned gap;
        bit          drain;
    } host_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic strobe;
    res_t result;

    host_req_t pending_reqs[$];
    res_t      expected_cmds[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        hang_count = 0;

    // shadow of the translation state
    logic [BLK_W-1:0] lbn_to_pbn [DATA_BLKS];
    bit               lbn_mapped [DATA_BLKS];
    logic [BLK_W-1:0] spare_pbn;
    bit               pbn_taken  [BLOCK_COUNT];
    bit               page_done  [BLOCK_COUNT*PAGES_PER_BLK];

    block_mapped_flash_translation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .strobe (strobe),
        .result (result)
    );

    always #5 clk = ~clk;

    // build one flash command; last is patched on the final one of a request
    function automatic res_t flash_cmd(input logic [2:0] op, input int dst, input int src,
                                       input int lbn, input bit hl, input int lsn,
                                       input bit hs, input logic [1:0] st);
        res_t c;
        c.op        = op;
        c.dst_ppn   = PPN_W'(dst);
        c.src_ppn   = PPN_W'(src);
        c.spare_lbn = BLK_W'(lbn);
        c.has_lbn   = hl;
        c.spare_lsn = LSN_W'(lsn);
        c.has_lsn   = hs;
        c.status    = st;
        c.last      = 1'b0;
        return c;
    endfunction

    // work out the flash commands one request causes and update the shadow map
    task automatic translate_request(input req_t r);
        int   lbn;
        int   off;
        int   base;
        int   obase;
        int   sbase;
        int   old_pbn;
        int   new_pbn;
        int   hit;
        bit   first_pg;
        res_t cmds[$];
        lbn      = int'(r.lsn) / PAGES_PER_BLK;
        off      = int'(r.lsn) % PAGES_PER_BLK;
        first_pg = (off == 0);
        if (lbn >= DATA_BLKS)
        begin
            // last logical block is reserved for the spare, no flash access
            cmds.push_back(flash_cmd(OP_NONE, 0, 0, 0, 0, 0, 0, ST_RANGE));
        end
        else if (!r.req_type)
        begin
            // reads of unwritten pages in a mapped block still go to flash
            if (!lbn_mapped[lbn])
                cmds.push_back(flash_cmd(OP_NONE, 0, 0, 0, 0, 0, 0, ST_UNMAPPED));
            else
                cmds.push_back(flash_cmd(OP_READ, int'(lbn_to_pbn[lbn]) * PAGES_PER_BLK + off,
                                         0, 0, 0, 0, 0, ST_OK));
        end
        else if (!lbn_mapped[lbn])
        begin
            // first write: lowest block neither taken nor the spare
            hit = -1;
            for (int b = 0; b < BLOCK_COUNT; b++)
            begin
                if (hit < 0 && b != int'(spare_pbn) && !pbn_taken[b])
                    hit = b;
            end
            if (hit < 0)
            begin
                cmds.push_back(flash_cmd(OP_NONE, 0, 0, 0, 0, 0, 0, ST_NOFREE));
            end
            else
            begin
                base              = hit * PAGES_PER_BLK;
                lbn_to_pbn[lbn]   = BLK_W'(hit);
                lbn_mapped[lbn]   = 1'b1;
                pbn_taken[hit]    = 1'b1;
                page_done[base + off] = 1'b1;
                cmds.push_back(flash_cmd(OP_PROG, base + off, 0, first_pg ? lbn : 0, first_pg,
                                         int'(r.lsn), 1'b1, ST_OK));
                // page 0 not touched by the host: tag it with the lbn marker,
                // which leaves its written bit clear
                if (!first_pg)
                    cmds.push_back(flash_cmd(OP_MARK, base, 0, lbn, 1'b1, 0, 0, ST_OK));
            end
        end
        else
        begin
            old_pbn = int'(lbn_to_pbn[lbn]);
            obase   = old_pbn * PAGES_PER_BLK;
            if (!page_done[obase + off])
            begin
                // in-place program of a fresh page
                page_done[obase + off] = 1'b1;
                cmds.push_back(flash_cmd(OP_PROG, obase + off, 0, first_pg ? lbn : 0, first_pg,
                                         int'(r.lsn), 1'b1, ST_OK));
            end
            else
            begin
                // merge: copy every other page into the spare, written or not
                new_pbn = int'(spare_pbn);
                sbase   = new_pbn * PAGES_PER_BLK;
                for (int i = 0; i < PAGES_PER_BLK; i++)
                begin
                    if (i != off)
                    begin
                        page_done[sbase + i] = page_done[obase + i];
                        cmds.push_back(flash_cmd(OP_COPY, sbase + i, obase + i, 0, 0, 0, 0,
                                                 ST_OK));
                    end
                end
                page_done[sbase + off] = 1'b1;
                cmds.push_back(flash_cmd(OP_PROG, sbase + off, 0, first_pg ? lbn : 0, first_pg,
                                         int'(r.lsn), 1'b1, ST_OK));
                lbn_to_pbn[lbn]    = BLK_W'(new_pbn);
                pbn_taken[new_pbn] = 1'b1;
                pbn_taken[old_pbn] = 1'b0;
                for (int i = 0; i < PAGES_PER_BLK; i++)
                    page_done[obase + i] = 1'b0;
                // the erased old block becomes the next spare
                cmds.push_back(flash_cmd(OP_ERASE, obase, 0, 0, 0, 0, 0, ST_OK));
                spare_pbn = BLK_W'(old_pbn);
            end
        end
        cmds[cmds.size() - 1].last = 1'b1;
        foreach (cmds[i])
            expected_cmds.push_back(cmds[i]);
    endtask

    task automatic queue_request(input bit wr, input int lsn, input int unsigned gap,
                                 input bit drain);
        host_req_t h;
        h.r.req_type = wr;
        h.r.lsn      = LSN_W'(lsn);
        h.gap        = gap;
        h.drain      = drain;
        pending_reqs.push_back(h);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // driver: raises start for the head of the queue once its gap has passed;
    // on a transfer with the next request ready, start simply stays high
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin : drive
            bit taken_now;
            bit issue;
            taken_now = start && !busy;
            if (taken_now)
                idle_cycles = 0;
            else if (!start && idle_cycles < HANG_LIMIT)
                idle_cycles++;
            if (taken_now || !start)
            begin
                issue = pending_reqs.size() != 0 && idle_cycles >= int'(pending_reqs[0].gap);
                // hold-off: only when no command is in flight; strobe low and no
                // transfer now means the monitor leaves the queue alone this edge
                if (issue && pending_reqs[0].drain)
                    issue = !taken_now && !strobe && expected_cmds.size() == 0;
                if (issue)
                begin
                    start <= 1'b1;
                    req   <= pending_reqs[0].r;
                    void'(pending_reqs.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: the command on the port is checked first, then a request taken
    // at the same edge is predicted, so order within the edge is fixed
    always @(posedge clk)
    begin : observe
        res_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected command: op %0d dst %0d", result.op, result.dst_ppn);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("op", want.op, result.op);
                    check_field("dst_ppn", want.dst_ppn, result.dst_ppn);
                    check_field("src_ppn", want.src_ppn, result.src_ppn);
                    check_field("spare_lbn", want.spare_lbn, result.spare_lbn);
                    check_field("has_lbn", want.has_lbn, result.has_lbn);
                    check_field("spare_lsn", want.spare_lsn, result.spare_lsn);
                    check_field("has_lsn", want.has_lsn, result.has_lsn);
                    check_field("status", want.status, result.status);
                    check_field("last", want.last, result.last);
                end
            end
            if (start && !busy)
                translate_request(req);
        end
    end

    // watchdog on transfers in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                hang_count <= 0;
            else
                hang_count <= hang_count + 1;
            if (hang_count >= HANG_LIMIT)
            begin
                $display("** block_mapped_flash_translation: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned gap_mode;
        int unsigned gap;
        // fresh device
        foreach (lbn_mapped[i])
        begin
            lbn_mapped[i] = 1'b0;
            lbn_to_pbn[i] = '0;
        end
        foreach (pbn_taken[i])
            pbn_taken[i] = 1'b0;
        foreach (page_done[i])
            page_done[i] = 1'b0;
        spare_pbn  = BLK_W'(BLOCK_COUNT - 1);

        // directed: error cases, allocation with and without marker, in-place
        // programs, merges at first, middle and last offset
        queue_request(1'b0, 0, 0, 1'b0);      // read of unmapped block
        queue_request(1'b0, 127, 3, 1'b0);    // read beyond the data blocks
        queue_request(1'b1, 127, 0, 1'b0);    // write beyond the data blocks
        queue_request(1'b1, 120, 0, 1'b0);
        queue_request(1'b1, 0, 5, 1'b0);      // first write at offset 0, carries lbn
        queue_request(1'b1, 13, 0, 1'b0);     // first write mid-block, then marker
        queue_request(1'b0, 13, 0, 1'b0);
        queue_request(1'b0, 14, 2, 1'b0);     // unwritten page of mapped block
        queue_request(1'b1, 14, 0, 1'b0);     // in-place program
        queue_request(1'b1, 13, 0, 1'b1);     // merge, issued on an empty pipe
        queue_request(1'b1, 8, 0, 1'b0);      // page 0 after marker-only copy
        queue_request(1'b1, 8, 14, 1'b0);     // merge at offset 0
        queue_request(1'b1, 119, 0, 1'b0);    // highest data sector
        queue_request(1'b1, 119, 0, 1'b0);    // merge at last offset
        queue_request(1'b0, 119, 1, 1'b0);
        queue_request(1'b1, 0, 0, 1'b0);
        queue_request(1'b0, 0, 0, 1'b0);
        queue_request(1'b1, 112, 7, 1'b0);
        queue_request(1'b0, 120, 0, 1'b0);
        queue_request(1'b0, 7, 0, 1'b0);

        // random: mostly writes so blocks fill up and merges chain; the gap
        // style changes every few dozen requests so back-to-back runs appear
        gap_mode = 0;
        for (int n = 0; n < 350; n++)
        begin
            if (n % 40 == 0)
                gap_mode = $urandom_range(0, 2);
            gap = (gap_mode == 0) ? 0 : $urandom_range(0, 14);
            queue_request($urandom_range(0, 99) < 65, $urandom_range(0, 127), gap,
                          $urandom_range(0, 39) == 0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start)
            @(negedge clk);
        while (expected_cmds.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("** block_mapped_flash_translation: PASSED **");
        else
            $display("** block_mapped_flash_translation: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
